@@ hw/rtl/x86pm_pkg.sv @@
// Shared types and constants for the x86 prefix/ModRM/SIB decoder.
// Depends on nothing; imported by x86_subset_prefix_modrm_decoder.
`timescale 1ns / 1ps
`default_nettype none

package x86pm_pkg;

    // Prefix bytes
    localparam logic [7:0] C_LOCK_PREFIX = 8'hF0;
    localparam logic [7:0] C_ADDR_PREFIX = 8'h67;

    // Opcodes that take a ModRM byte
    localparam logic [7:0] C_OPC_ADD_RM8 = 8'h00;
    localparam logic [7:0] C_OPC_AND_RM8 = 8'h20;
    localparam logic [7:0] C_OPC_OR_RM8  = 8'h08;
    localparam logic [7:0] C_OPC_GRP3_8  = 8'hF6;

    // ModRM fields that call for a SIB byte
    localparam logic [2:0] C_RM_SIB      = 3'b100;
    localparam logic [1:0] C_MOD_REG     = 2'b11;

    localparam logic [3:0] C_TALLY_MAX   = 4'hF;

    // Byte position inside the instruction
    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_MODRM  = 2'd1,
        PH_SIB    = 2'd2
    } t_phase;

    // One decoded instruction
    typedef struct packed {
        logic       valid_res;
        logic       lock_seen;
        logic [3:0] lock_count;
        logic       addr_size_seen;
        logic [3:0] addr_size_count;
        logic [7:0] opcode_byte;
        logic [7:0] modrm_byte;
        logic       has_sib;
        logic [7:0] sib_byte;
    } t_result;

    function automatic logic is_known_opcode(input logic [7:0] b);
        return (b == C_OPC_ADD_RM8) || (b == C_OPC_AND_RM8) ||
               (b == C_OPC_OR_RM8)  || (b == C_OPC_GRP3_8);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/x86_subset_prefix_modrm_decoder.sv @@
// Decoder for a subset of x86: lock / address-size prefixes, opcode, ModRM, SIB.
// Takes one code byte per cycle while o_in_ready is high; the result of the byte
// that ends an instruction is registered in the output register or skid entry.
// Throughput is 1 byte per cycle unless the skid entry is full; a two-entry output
// stage (register plus skid) lets bytes keep going while one result waits downstream.
// Synchronous active-low reset clears the phase, prefix state, held bytes and output valids.
`timescale 1ns / 1ps
`default_nettype none

module x86_subset_prefix_modrm_decoder
    import x86pm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Byte stream in
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_code_byte,
    // Decoded instruction out
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_valid_res,
    output logic            o_lock_seen,
    output logic [3:0]      o_lock_count,
    output logic            o_addr_size_seen,
    output logic [3:0]      o_addr_size_count,
    output logic [7:0]      o_opcode_byte,
    output logic [7:0]      o_modrm_byte,
    output logic            o_has_sib,
    output logic [7:0]      o_sib_byte
);

    // Decoder state
    t_phase     r_phase,      n_phase;
    logic       r_lock_flag,  n_lock_flag;
    logic [3:0] r_lock_tally, n_lock_tally;
    logic       r_addr_flag,  n_addr_flag;
    logic [3:0] r_addr_tally, n_addr_tally;
    logic [7:0] r_held_opcode, n_held_opcode;
    logic [7:0] r_held_modrm,  n_held_modrm;

    // Output register and skid entry
    logic       r_out_vld;
    t_result    r_out;
    logic       r_skid_vld;
    t_result    r_skid;

    logic       in_accept;
    logic       res_emit;
    t_result    res;
    logic       sib_needed;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_skid_vld;
    assign sib_needed = (i_code_byte[2:0] == C_RM_SIB) &&
                        (i_code_byte[7:6] != C_MOD_REG) && !r_addr_flag;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (in_accept) begin
            unique case (r_phase)
                PH_MODRM: n_phase = sib_needed ? PH_SIB : PH_PREFIX;
                PH_SIB:   n_phase = PH_PREFIX;
                default: begin
                    n_phase = is_known_opcode(i_code_byte) ? PH_MODRM : PH_PREFIX;
                end
            endcase
        end
    end

    // Prefix bookkeeping, held bytes and the result of this byte
    always_comb begin
        n_lock_flag   = r_lock_flag;
        n_lock_tally  = r_lock_tally;
        n_addr_flag   = r_addr_flag;
        n_addr_tally  = r_addr_tally;
        n_held_opcode = r_held_opcode;
        n_held_modrm  = r_held_modrm;
        res_emit      = 1'b0;

        res.valid_res       = 1'b1;
        res.lock_seen       = r_lock_flag;
        res.lock_count      = r_lock_tally;
        res.addr_size_seen  = r_addr_flag;
        res.addr_size_count = r_addr_tally;
        res.opcode_byte     = r_held_opcode;
        res.modrm_byte      = i_code_byte;
        res.has_sib         = 1'b0;
        res.sib_byte        = 8'h00;

        if (in_accept) begin
            unique case (r_phase)
                PH_MODRM: begin
                    n_held_modrm = i_code_byte;
                    res_emit     = !sib_needed;
                end
                PH_SIB: begin
                    res.modrm_byte = r_held_modrm;
                    res.has_sib    = 1'b1;
                    res.sib_byte   = i_code_byte;
                    res_emit       = 1'b1;
                end
                default: begin
                    priority if (i_code_byte == C_LOCK_PREFIX) begin
                        n_lock_flag = 1'b1;
                        if (r_lock_tally != C_TALLY_MAX)
                            n_lock_tally = r_lock_tally + 4'd1;
                    end else if (i_code_byte == C_ADDR_PREFIX) begin
                        n_addr_flag = 1'b1;
                        if (r_addr_tally != C_TALLY_MAX)
                            n_addr_tally = r_addr_tally + 4'd1;
                    end else if (is_known_opcode(i_code_byte)) begin
                        n_held_opcode = i_code_byte;
                    end else begin
                        // unknown opcode byte ends the instruction
                        res.valid_res   = 1'b0;
                        res.opcode_byte = i_code_byte;
                        res.modrm_byte  = 8'h00;
                        res_emit        = 1'b1;
                    end
                end
            endcase

            // prefix state clears after every result
            if (res_emit) begin
                n_lock_flag  = 1'b0;
                n_lock_tally = 4'd0;
                n_addr_flag  = 1'b0;
                n_addr_tally = 4'd0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_lock_flag  <= 1'b0;
            r_lock_tally <= 4'd0;
            r_addr_flag  <= 1'b0;
            r_addr_tally <= 4'd0;
        end else begin
            r_phase      <= n_phase;
            r_lock_flag  <= n_lock_flag;
            r_lock_tally <= n_lock_tally;
            r_addr_flag  <= n_addr_flag;
            r_addr_tally <= n_addr_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_opcode <= 8'h00;
            r_held_modrm  <= 8'h00;
        end else begin
            r_held_opcode <= n_held_opcode;
            r_held_modrm  <= n_held_modrm;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= res_emit;
            end
        end else if (res_emit) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (res_emit) begin
            r_skid <= res;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_valid_res       = r_out.valid_res;
    assign o_lock_seen       = r_out.lock_seen;
    assign o_lock_count      = r_out.lock_count;
    assign o_addr_size_seen  = r_out.addr_size_seen;
    assign o_addr_size_count = r_out.addr_size_count;
    assign o_opcode_byte     = r_out.opcode_byte;
    assign o_modrm_byte      = r_out.modrm_byte;
    assign o_has_sib         = r_out.has_sib;
    assign o_sib_byte        = r_out.sib_byte;

`ifndef SYNTH
    // skid entry only fills behind a waiting output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid while output register empty");

    // a SIB byte is never expected after an address-size prefix
    a_sib_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIB) |-> !r_addr_flag)
        else $error("SIB phase with address-size prefix pending");

    // flags and counts agree
    a_lock_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_flag == (r_lock_tally != 4'd0))
        else $error("lock flag and count disagree");

    a_addr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr_flag == (r_addr_tally != 4'd0))
        else $error("address-size flag and count disagree");

    // prefix state is clear after a result has been produced
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_emit |=> (r_phase == PH_PREFIX) && !r_lock_flag && !r_addr_flag)
        else $error("prefix state not cleared after result");
`endif

endmodule

`default_nettype wire

@@ tb/x86pm_checker.sv @@
// Scoreboard for the x86 prefix/ModRM/SIB decoder: watches both channels,
// predicts each decoded instruction and compares it with what comes out.
// Depends on x86pm_pkg for the result struct, phase enum and byte constants.
`timescale 1ns / 1ps

module x86pm_checker
    import x86pm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Byte stream into the decoder
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_code_byte,
    // Decoded instruction out of the decoder
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_valid_res,
    input  logic       i_lock_seen,
    input  logic [3:0] i_lock_count,
    input  logic       i_addr_size_seen,
    input  logic [3:0] i_addr_size_count,
    input  logic [7:0] i_opcode_byte,
    input  logic [7:0] i_modrm_byte,
    input  logic       i_has_sib,
    input  logic [7:0] i_sib_byte,
    // Status for the test top
    output int         o_fail_count,
    output int         o_pending,
    output int         o_insn_count,
    output int         o_sib_count,
    output int         o_bad_opcode_count,
    output int         o_saturated_count
);

    // Decoder state as the scoreboard sees it
    t_phase     ph;
    logic       lock_seen;
    logic [3:0] lock_cnt;
    logic       addr_seen;
    logic [3:0] addr_cnt;
    logic [7:0] held_opc;
    logic [7:0] held_modrm;

    t_result    expected_insns[$];
    t_result    got;
    t_result    want;

    function automatic t_result make_insn(input logic ok, input logic [7:0] opc,
                                          input logic [7:0] modrm, input logic sib_ok,
                                          input logic [7:0] sib);
        t_result r;
        r.valid_res       = ok;
        r.lock_seen       = lock_seen;
        r.lock_count      = lock_cnt;
        r.addr_size_seen  = addr_seen;
        r.addr_size_count = addr_cnt;
        r.opcode_byte     = opc;
        r.modrm_byte      = modrm;
        r.has_sib         = sib_ok;
        r.sib_byte        = sib;
        return r;
    endfunction

    function automatic string fmt_insn(input t_result r);
        return $sformatf("ok=%0b lock=%0b/%0d asz=%0b/%0d op=%02h modrm=%02h sib=%0b/%02h",
                         r.valid_res, r.lock_seen, r.lock_count, r.addr_size_seen,
                         r.addr_size_count, r.opcode_byte, r.modrm_byte, r.has_sib,
                         r.sib_byte);
    endfunction

    // Advance the decoder model by one code byte; queue an instruction if one ends
    task automatic decode_byte(input logic [7:0] b);
        t_result r;
        logic    done;
        r    = '0;
        done = 1'b0;
        case (ph)
            PH_MODRM: begin
                held_modrm = b;
                if (b[2:0] == C_RM_SIB && b[7:6] != C_MOD_REG && !addr_seen) begin
                    ph = PH_SIB;
                end else begin
                    r    = make_insn(1'b1, held_opc, b, 1'b0, 8'h00);
                    done = 1'b1;
                end
            end
            PH_SIB: begin
                r    = make_insn(1'b1, held_opc, held_modrm, 1'b1, b);
                done = 1'b1;
            end
            default: begin
                // prefix or opcode position
                if (b == C_LOCK_PREFIX) begin
                    lock_seen = 1'b1;
                    if (lock_cnt != C_TALLY_MAX) lock_cnt = lock_cnt + 4'd1;
                    ph = PH_PREFIX;
                end else if (b == C_ADDR_PREFIX) begin
                    addr_seen = 1'b1;
                    if (addr_cnt != C_TALLY_MAX) addr_cnt = addr_cnt + 4'd1;
                    ph = PH_PREFIX;
                end else begin
                    case (b)
                        C_OPC_ADD_RM8, C_OPC_AND_RM8, C_OPC_OR_RM8, C_OPC_GRP3_8: begin
                            held_opc = b;
                            ph       = PH_MODRM;
                        end
                        default: begin
                            r    = make_insn(1'b0, b, 8'h00, 1'b0, 8'h00);
                            done = 1'b1;
                        end
                    endcase
                end
            end
        endcase
        if (done) begin
            expected_insns.push_back(r);
            ph        = PH_PREFIX;
            lock_seen = 1'b0;
            lock_cnt  = '0;
            addr_seen = 1'b0;
            addr_cnt  = '0;
        end
    endtask

    always_comb begin
        got.valid_res       = i_valid_res;
        got.lock_seen       = i_lock_seen;
        got.lock_count      = i_lock_count;
        got.addr_size_seen  = i_addr_size_seen;
        got.addr_size_count = i_addr_size_count;
        got.opcode_byte     = i_opcode_byte;
        got.modrm_byte      = i_modrm_byte;
        got.has_sib         = i_has_sib;
        got.sib_byte        = i_sib_byte;
    end

    initial begin
        o_fail_count       = 0;
        o_pending          = 0;
        o_insn_count       = 0;
        o_sib_count        = 0;
        o_bad_opcode_count = 0;
        o_saturated_count  = 0;
    end

    // Compare finished instructions first, then feed the accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph         = PH_PREFIX;
            lock_seen  = 1'b0;
            lock_cnt   = '0;
            addr_seen  = 1'b0;
            addr_cnt   = '0;
            held_opc   = '0;
            held_modrm = '0;
            expected_insns.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_insns.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("%0t: instruction out with none expected: %s",
                                 $realtime, fmt_insn(got));
                end else begin
                    want = expected_insns.pop_front();
                    o_insn_count = o_insn_count + 1;
                    if (want.has_sib) o_sib_count = o_sib_count + 1;
                    if (!want.valid_res) o_bad_opcode_count = o_bad_opcode_count + 1;
                    if (want.lock_count == C_TALLY_MAX || want.addr_size_count == C_TALLY_MAX)
                        o_saturated_count = o_saturated_count + 1;
                    if (got !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch on instruction %0d", $realtime,
                                     o_insn_count);
                            $display("  expected %s", fmt_insn(want));
                            $display("  actual   %s", fmt_insn(got));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_byte(i_code_byte);
        end
        o_pending <= expected_insns.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Test top for x86_subset_prefix_modrm_decoder: drives the code byte stream
// and output back-pressure, gives the verdict. Needs x86pm_pkg and x86pm_checker.
`timescale 1ns / 1ps

module tb_top;
    import x86pm_pkg::*;

    localparam int N_ITEMS = 850;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_code_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_valid_res;
    logic       o_lock_seen;
    logic [3:0] o_lock_count;
    logic       o_addr_size_seen;
    logic [3:0] o_addr_size_count;
    logic [7:0] o_opcode_byte;
    logic [7:0] o_modrm_byte;
    logic       o_has_sib;
    logic [7:0] o_sib_byte;

    int fail_count, pending, insn_count, sib_count, bad_opc_count, sat_count;
    int bytes_sent;
    int tx_idle_pct;
    int rx_idle_pct;

    always #5 i_clk = ~i_clk;

    x86_subset_prefix_modrm_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_code_byte       (i_code_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_valid_res       (o_valid_res),
        .o_lock_seen       (o_lock_seen),
        .o_lock_count      (o_lock_count),
        .o_addr_size_seen  (o_addr_size_seen),
        .o_addr_size_count (o_addr_size_count),
        .o_opcode_byte     (o_opcode_byte),
        .o_modrm_byte      (o_modrm_byte),
        .o_has_sib         (o_has_sib),
        .o_sib_byte        (o_sib_byte)
    );

    x86pm_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_code_byte        (i_code_byte),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_valid_res        (o_valid_res),
        .i_lock_seen        (o_lock_seen),
        .i_lock_count       (o_lock_count),
        .i_addr_size_seen   (o_addr_size_seen),
        .i_addr_size_count  (o_addr_size_count),
        .i_opcode_byte      (o_opcode_byte),
        .i_modrm_byte       (o_modrm_byte),
        .i_has_sib          (o_has_sib),
        .i_sib_byte         (o_sib_byte),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_insn_count       (insn_count),
        .o_sib_count        (sib_count),
        .o_bad_opcode_count (bad_opc_count),
        .o_saturated_count  (sat_count)
    );

    // Offer one byte, with random gaps ahead of it; returns at the falling edge
    // after the byte was taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent = bytes_sent + 1;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every queued instruction has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One random instruction: mostly well formed, some bad opcodes and raw noise
    task automatic send_insn();
        int         kind;
        int         sel;
        int         npfx;
        int         pfx_mode;
        logic       addr_sent;
        logic [7:0] op;
        logic [7:0] modrm;
        kind      = $urandom_range(99);
        sel       = $urandom_range(99);
        pfx_mode  = $urandom_range(2);
        addr_sent = 1'b0;
        if (kind < 8) begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        if (sel < 45)      npfx = 0;
        else if (sel < 85) npfx = $urandom_range(3, 1);
        else if (sel < 93) npfx = $urandom_range(8, 4);
        else               npfx = $urandom_range(20, 14);
        // prefixes: lock only, address-size only, or mixed
        for (int k = 0; k < npfx; k++) begin
            if (pfx_mode == 0 || (pfx_mode == 2 && $urandom_range(1) == 0)) begin
                send_byte(C_LOCK_PREFIX);
            end else begin
                send_byte(C_ADDR_PREFIX);
                addr_sent = 1'b1;
            end
        end
        if (kind < 22) begin
            op = 8'($urandom_range(255));
            while (op == C_LOCK_PREFIX || op == C_ADDR_PREFIX || op == C_OPC_ADD_RM8 ||
                   op == C_OPC_AND_RM8 || op == C_OPC_OR_RM8 || op == C_OPC_GRP3_8)
                op = 8'($urandom_range(255));
            send_byte(op);
            return;
        end
        case ($urandom_range(3))
            0:       op = C_OPC_ADD_RM8;
            1:       op = C_OPC_AND_RM8;
            2:       op = C_OPC_OR_RM8;
            default: op = C_OPC_GRP3_8;
        endcase
        modrm = 8'($urandom_range(255));
        if ($urandom_range(1) == 0) modrm[2:0] = C_RM_SIB;
        send_byte(op);
        send_byte(modrm);
        if (modrm[2:0] == C_RM_SIB && modrm[7:6] != C_MOD_REG && !addr_sent)
            send_byte(8'($urandom_range(255)));
    endtask

    // Receiver back-pressure, with one long hold-off that fills the output stage
    initial begin
        int cyc;
        cyc         = 0;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc = cyc + 1;
            if (cyc >= 150 && cyc < 230) i_out_ready <= 1'b0;
            else i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [7:0] directed[$];
        directed = '{
            C_LOCK_PREFIX, C_OPC_ADD_RM8, 8'hC0,                       // lock, reg-direct
            C_ADDR_PREFIX, C_ADDR_PREFIX, C_OPC_AND_RM8, 8'h04,        // addr-size blocks SIB
            C_OPC_OR_RM8, 8'h44, 8'hFF,                                // disp8 with SIB
            C_OPC_GRP3_8, 8'hC4,                                       // mod 11, rm 100
            C_OPC_ADD_RM8, 8'h04, 8'h00,                               // SIB, all zero
            C_LOCK_PREFIX, C_ADDR_PREFIX, C_OPC_GRP3_8, 8'hBC,         // both prefixes
            8'hFF,                                                     // bad opcode
            C_LOCK_PREFIX, C_LOCK_PREFIX, C_ADDR_PREFIX, 8'h90         // bad opcode, prefixed
        };
        bytes_sent  = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 73;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_code_byte = 8'h00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) send_byte(directed[k]);

        // slow receiver
        while (bytes_sent < 300) send_insn();
        drain();
        // slow sender
        tx_idle_pct = 73;
        rx_idle_pct = 29;
        while (bytes_sent < 580) send_insn();
        drain();
        // full rate both ways
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (bytes_sent < N_ITEMS) send_insn();
        drain();
        repeat (20) @(posedge i_clk);

        $display("tb: %0d code bytes sent, %0d instructions checked", bytes_sent, insn_count);
        $display("tb: %0d with SIB, %0d bad opcodes, %0d with a saturated prefix count",
                 sib_count, bad_opc_count, sat_count);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ x86_subset_prefix_modrm_decoder.f @@
hw/rtl/x86pm_pkg.sv
hw/rtl/x86_subset_prefix_modrm_decoder.sv
tb/x86pm_checker.sv
tb/tb_top.sv
